// File: hdl/mec_pkg.sv
// Shared types and constants for the Mandelbrot escape-time counter.
// No dependencies; used by mec_ctrl, mec_datapath and the top level.
package mec_pkg;

  localparam int FRAC_BITS = 28;
  localparam int C_W       = 32;
  localparam int CNT_W     = 12;
  localparam int MAG_W     = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int SQ_W      = PROD_W - FRAC_BITS;
  localparam int XY_W      = PROD_W - FRAC_BITS + 1;
  localparam int Z_W       = ((FRAC_BITS + 3 > C_W) ? FRAC_BITS + 3 : C_W) + 2;

  localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(511);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic upd_en;
  } cmd_t;

  typedef struct packed {
    logic limit;
    logic big;
    logic outside;
  } status_t;

endpackage

// File: hdl/mandelbrot_escape_count_core.sv
// Mandelbrot escape-time counter, top level: config register, output register.
// Each iteration is a multiply step (ST_MUL), then the escape test and update of z
// (ST_UPD); an item ends when the iteration limit is reached or the point escapes,
// and its result waits while the output is stalled.
// A new item is accepted the cycle after the previous result is registered.
// Reset (rst, synchronous) sets max_iterations to 511 and empties the output.
// Depends on mec_pkg, mec_ctrl, mec_datapath.
module mandelbrot_escape_count_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [mec_pkg::C_W-1:0]   c_real,
  input  logic signed [mec_pkg::C_W-1:0]   c_imag,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic        [mec_pkg::CNT_W-1:0] escape_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic        [mec_pkg::CNT_W-1:0] cfg_data
);

  logic [mec_pkg::CNT_W-1:0] max_iterations;
  logic [mec_pkg::CNT_W-1:0] count;
  logic                      out_load;
  logic                      out_busy;
  mec_pkg::cmd_t             cmd;
  mec_pkg::status_t          status;

  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= mec_pkg::MAX_ITER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_iterations <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      escape_count <= count;
    end
  end

  mec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_load (out_load),
    .out_busy (out_busy),
    .cmd      (cmd),
    .status   (status)
  );

  mec_datapath u_dp (
    .clk            (clk),
    .c_real         (c_real),
    .c_imag         (c_imag),
    .max_iterations (max_iterations),
    .cmd            (cmd),
    .status         (status),
    .count          (count)
  );

endmodule

// File: hdl/mec_ctrl.sv
// Sequencer for the escape-time iteration: accept, multiply, update, finish.
// Depends on mec_pkg; drives mec_datapath through cmd_t, reads status_t.
module mec_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_load,
  input  logic              out_busy,
  output mec_pkg::cmd_t     cmd,
  input  mec_pkg::status_t  status
);

  mec_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    cmd        = '0;
    unique case (state)
      mec_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mec_pkg::ST_MUL;
        end
      end
      mec_pkg::ST_MUL: begin
        if (status.limit) begin
          state_next = mec_pkg::ST_FIN;
        end else begin
          cmd.mul_en = 1'b1;
          state_next = mec_pkg::ST_UPD;
        end
      end
      mec_pkg::ST_UPD: begin
        if (status.big || status.outside) begin
          state_next = mec_pkg::ST_FIN;
        end else begin
          cmd.upd_en = 1'b1;
          state_next = mec_pkg::ST_MUL;
        end
      end
      mec_pkg::ST_FIN: begin
        if (!out_busy) begin
          out_load   = 1'b1;
          state_next = mec_pkg::ST_IDLE;
        end
      end
      default: state_next = mec_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hdl/mec_datapath.sv
// Datapath: z registers, magnitude squarings, escape test, z update, count.
// Depends on mec_pkg; commanded by mec_ctrl.
module mec_datapath (
  input  logic                               clk,
  input  logic signed [mec_pkg::C_W-1:0]     c_real,
  input  logic signed [mec_pkg::C_W-1:0]     c_imag,
  input  logic        [mec_pkg::CNT_W-1:0]   max_iterations,
  input  mec_pkg::cmd_t                      cmd,
  output mec_pkg::status_t                   status,
  output logic        [mec_pkg::CNT_W-1:0]   count
);

  localparam logic [mec_pkg::Z_W-1:0] TWO =
    mec_pkg::Z_W'(2) << mec_pkg::FRAC_BITS;
  localparam logic [mec_pkg::PROD_W:0] THR =
    (mec_pkg::PROD_W + 1)'(1) << (2 * mec_pkg::FRAC_BITS + 2);

  logic signed [mec_pkg::C_W-1:0]    cx, cy;
  logic signed [mec_pkg::Z_W-1:0]    x, y;
  logic        [mec_pkg::Z_W-1:0]    ax, ay;
  logic        [mec_pkg::MAG_W-1:0]  mx, my;
  logic        [mec_pkg::PROD_W-1:0] xx, yy, xy;
  logic                              big, neg;
  logic        [mec_pkg::PROD_W:0]   sum;
  logic        [mec_pkg::SQ_W-1:0]   sqx, sqy;
  logic        [mec_pkg::XY_W-1:0]   pxy;
  logic signed [mec_pkg::Z_W-1:0]    twoxy, x_next, y_next;

  assign ax = x[mec_pkg::Z_W-1] ? mec_pkg::Z_W'(-x) : mec_pkg::Z_W'(x);
  assign ay = y[mec_pkg::Z_W-1] ? mec_pkg::Z_W'(-y) : mec_pkg::Z_W'(y);
  assign mx = ax[mec_pkg::MAG_W-1:0];
  assign my = ay[mec_pkg::MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      xx  <= mec_pkg::PROD_W'(mx * mx);
      yy  <= mec_pkg::PROD_W'(my * my);
      xy  <= mec_pkg::PROD_W'(mx * my);
      big <= (ax >= TWO) || (ay >= TWO);
      neg <= x[mec_pkg::Z_W-1] ^ y[mec_pkg::Z_W-1];
    end
  end

  assign sum = {1'b0, xx} + {1'b0, yy};
  assign sqx = xx[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS];
  assign sqy = yy[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS];
  assign pxy = xy[mec_pkg::PROD_W-1:mec_pkg::FRAC_BITS-1];

  assign twoxy  = neg ? -$signed(mec_pkg::Z_W'(pxy)) : $signed(mec_pkg::Z_W'(pxy));
  assign x_next = $signed(mec_pkg::Z_W'(sqx)) - $signed(mec_pkg::Z_W'(sqy))
                + mec_pkg::Z_W'(cx);
  assign y_next = twoxy + mec_pkg::Z_W'(cy);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= c_real;
      cy    <= c_imag;
      x     <= mec_pkg::Z_W'(c_real);
      y     <= mec_pkg::Z_W'(c_imag);
      count <= '0;
    end else if (cmd.upd_en) begin
      x     <= x_next;
      y     <= y_next;
      count <= count + 1'b1;
    end
  end

  assign status.limit   = count >= max_iterations;
  assign status.big     = big;
  assign status.outside = sum >= THR;

endmodule
